### hdl/pse_pkg.sv
package pse_pkg;

    localparam int Capacity = 64;
    localparam int ValueWidth = 32;
    localparam int IdxW = $clog2(Capacity);
    localparam int CntW = $clog2(Capacity + 1);
    // Bits of the shift amount, one remainder step each.
    localparam int ModSteps = 31;

    // Action codes carried in the input beat.
    localparam logic [2:0] ACT_INSERT = 3'd0;
    localparam logic [2:0] ACT_REMOVE = 3'd1;
    localparam logic [2:0] ACT_DUMP   = 3'd2;
    localparam logic [2:0] ACT_MOVE   = 3'd3;
    localparam logic [2:0] ACT_REV    = 3'd4;
    localparam logic [2:0] ACT_ROTL   = 3'd5;
    localparam logic [2:0] ACT_ROTR   = 3'd6;
    localparam logic [2:0] ACT_BAD    = 3'd7;

    // Status codes of a result beat.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_MOD,
        S_RD,
        S_WR,
        S_DUMP_RD,
        S_DUMP_OUT,
        S_STATUS
    } pse_state_t;

    // Datapath operations ordered by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_DECODE,
        OP_MODSTEP,
        OP_READ,
        OP_WRITE,
        OP_COMMIT,
        OP_DUMP_LOAD,
        OP_STATUS_LOAD
    } pse_op_t;

    typedef struct packed {
        pse_op_t op;
    } pse_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       early;     // result is a plain status beat, no edit
        logic       mod_last;  // last remainder step
        logic       walk_done; // every entry of the new sequence written
        logic       dump_last; // current dump beat is the final one
    } pse_stat_t;

endpackage

### hdl/positional_sequence_editor_core.sv
// Channel  | Beat        | Fields of tdata / tuser (lowest bit up)
// s_axis   | one action  | tdata: action[2:0] value[34:3] position[40:35]
//          |             |        target_position[46:41] shift_amount[77:47]
// m_axis   | one result  | tdata: element[31:0] status[33:32] length[40:34]; tlast: last
// An action is taken only when idle; decode follows the accept cycle.
// An edit writes the new sequence into the other bank, a read state and a write state per entry,
// then commits and loads its status.
// A rotation first works out the remainder of the shift amount by the length, one bit per step.
// A dump reads and loads one beat per entry; a plain status action goes from decode to its status beat.
// Reset clears the length; the store is not cleared. A waiting result stalls the next load.
module positional_sequence_editor_core
    import pse_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // action, value, position, target_position, shift_amount
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // element, status, length
    output logic        m_axis_tlast   // last
);

    pse_cmd_t  cmd;
    pse_stat_t stat;
    logic      out_free;
    logic [31:0] el;
    logic [1:0]  st;
    logic [6:0]  len;

    pse_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (s_axis_tvalid && s_axis_tready),
        .out_free (out_free),
        .stat     (stat),
        .cmd      (cmd),
        .in_ready (s_axis_tready)
    );

    pse_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_action   (s_axis_tdata[2:0]),
        .in_value    (s_axis_tdata[34:3]),
        .in_position (s_axis_tdata[40:35]),
        .in_target   (s_axis_tdata[46:41]),
        .in_shift    (s_axis_tdata[77:47]),
        .out_take    (m_axis_tvalid && m_axis_tready),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_free    (out_free),
        .out_element (el),
        .out_last    (m_axis_tlast),
        .out_status  (st),
        .out_length  (len)
    );

    assign m_axis_tdata = {7'd0, len, st, el};

endmodule

### hdl/pse_ctrl.sv
module pse_ctrl
    import pse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_fire,
    input  logic      out_free,
    input  pse_stat_t stat,
    output pse_cmd_t  cmd,
    output logic      in_ready
);

    pse_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencing of one action.
    always_comb
    begin
        state_next = state_reg;
        cmd.op = OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_fire)
                begin
                    cmd.op = OP_LATCH;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.op = OP_DECODE;
                if (stat.early)
                begin
                    state_next = S_STATUS;
                end
                else if (stat.action == ACT_DUMP)
                begin
                    state_next = S_DUMP_RD;
                end
                else if (stat.action == ACT_ROTL || stat.action == ACT_ROTR)
                begin
                    state_next = S_MOD;
                end
                else
                begin
                    state_next = S_RD;
                end
            end
            S_MOD:
            begin
                cmd.op = OP_MODSTEP;
                if (stat.mod_last)
                begin
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                if (stat.walk_done)
                begin
                    cmd.op = OP_COMMIT;
                    state_next = S_STATUS;
                end
                else
                begin
                    cmd.op = OP_READ;
                    state_next = S_WR;
                end
            end
            S_WR:
            begin
                cmd.op = OP_WRITE;
                state_next = S_RD;
            end
            S_DUMP_RD:
            begin
                cmd.op = OP_READ;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    cmd.op = OP_DUMP_LOAD;
                    state_next = stat.dump_last ? S_IDLE : S_DUMP_RD;
                end
            end
            S_STATUS:
            begin
                if (out_free)
                begin
                    cmd.op = OP_STATUS_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### hdl/pse_dp.sv
module pse_dp
    import pse_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  pse_cmd_t              cmd,
    input  logic [2:0]            in_action,
    input  logic [31:0]           in_value,
    input  logic [5:0]            in_position,
    input  logic [5:0]            in_target,
    input  logic [30:0]           in_shift,
    input  logic                  out_take,
    output pse_stat_t             stat,
    output logic                  out_valid,
    output logic                  out_free,
    output logic [31:0]           out_element,
    output logic                  out_last,
    output logic [1:0]            out_status,
    output logic [6:0]            out_length
);

    // Two banks: an edit reads the live bank and writes the new sequence into the other.
    logic [ValueWidth-1:0] mem_a [Capacity];
    logic [ValueWidth-1:0] mem_b [Capacity];
    logic [ValueWidth-1:0] rda_reg, rdb_reg;
    logic                  bank_reg;    // set while bank b holds the live sequence

    logic [CntW-1:0]       count_reg;
    logic [2:0]            act_reg;
    logic [ValueWidth-1:0] val_reg;
    logic [CntW-1:0]       pos_reg, tgt_reg;
    logic [30:0]           shamt_reg;
    logic [CntW-1:0]       rem_reg;     // running remainder of shift_amount by the length
    logic [4:0]            mbit_reg;    // bit of the shift amount being fed
    logic [CntW-1:0]       i_reg;       // index in the new sequence or in the dump
    logic [1:0]            st_reg;

    logic                  ov_reg;
    logic [31:0]           oe_reg;
    logic                  ol_reg;
    logic [1:0]            os_reg;
    logic [CntW-1:0]       olen_reg;

    logic [CntW-1:0]       pos_c;
    logic [CntW-1:0]       new_len;
    logic [CntW:0]         rem_sh;
    logic [CntW-1:0]       rem_next;
    logic [CntW-1:0]       k_rot;
    logic [CntW:0]         rot_sum;
    logic [CntW-1:0]       rot_src;
    logic [CntW-1:0]       src_idx;
    logic                  use_val;
    logic [ValueWidth-1:0] rd_data;
    logic [ValueWidth-1:0] wr_data;
    logic                  early;
    logic [1:0]            early_st;

    assign pos_c = (pos_reg > count_reg) ? count_reg : pos_reg;

    // Plain status cases decided right after the beat is taken.
    always_comb
    begin
        early = 1'b0;
        early_st = ST_OK;
        if (act_reg == ACT_BAD)
        begin
            early = 1'b1;
            early_st = ST_RANGE;
        end
        else if (act_reg == ACT_INSERT)
        begin
            if (count_reg >= CntW'(Capacity))
            begin
                early = 1'b1;
                early_st = ST_FULL;
            end
        end
        else if (count_reg == '0)
        begin
            early = 1'b1;
            early_st = ST_EMPTY;
        end
        else if (act_reg == ACT_REMOVE && pos_reg >= count_reg)
        begin
            early = 1'b1;
            early_st = ST_RANGE;
        end
        else if (act_reg == ACT_MOVE
                 && (pos_reg >= count_reg || tgt_reg >= count_reg))
        begin
            early = 1'b1;
            early_st = ST_RANGE;
        end
    end

    // Length after the edit.
    always_comb
    begin
        case (act_reg)
            ACT_INSERT: new_len = CntW'(count_reg + 1'b1);
            ACT_REMOVE: new_len = CntW'(count_reg - 1'b1);
            default:    new_len = count_reg;
        endcase
    end

    // One restoring step of shift_amount mod length, most significant bit first.
    assign rem_sh = {rem_reg, shamt_reg[mbit_reg]};
    assign rem_next = (rem_sh >= {1'b0, count_reg}) ? CntW'(rem_sh - {1'b0, count_reg})
                                                    : CntW'(rem_sh);

    // Rotation start in the old sequence, and the wrapped source of entry i.
    assign k_rot = (act_reg == ACT_ROTL) ? rem_reg :
                   ((rem_reg == '0) ? '0 : CntW'(count_reg - rem_reg));
    assign rot_sum = {1'b0, i_reg} + {1'b0, k_rot};
    assign rot_src = (rot_sum >= {1'b0, count_reg}) ? CntW'(rot_sum - {1'b0, count_reg})
                                                    : CntW'(rot_sum);

    // Old index that feeds entry i of the new sequence.
    always_comb
    begin
        src_idx = i_reg;
        use_val = 1'b0;
        case (act_reg)
            ACT_INSERT:
            begin
                if (i_reg == pos_c)
                begin
                    use_val = 1'b1;
                end
                else if (i_reg > pos_c)
                begin
                    src_idx = CntW'(i_reg - 1'b1);
                end
            end
            ACT_REMOVE:
            begin
                if (i_reg >= pos_reg)
                begin
                    src_idx = CntW'(i_reg + 1'b1);
                end
            end
            ACT_MOVE:
            begin
                if (i_reg == tgt_reg)
                begin
                    src_idx = pos_reg;
                end
                else if (pos_reg < tgt_reg && i_reg >= pos_reg && i_reg < tgt_reg)
                begin
                    src_idx = CntW'(i_reg + 1'b1);
                end
                else if (pos_reg > tgt_reg && i_reg > tgt_reg && i_reg <= pos_reg)
                begin
                    src_idx = CntW'(i_reg - 1'b1);
                end
            end
            ACT_REV:
            begin
                src_idx = CntW'(count_reg - 1'b1 - i_reg);
            end
            ACT_ROTL, ACT_ROTR:
            begin
                src_idx = rot_src;
            end
            default:
            begin
            end
        endcase
    end

    assign rd_data = bank_reg ? rdb_reg : rda_reg;
    assign wr_data = use_val ? val_reg : rd_data;

    always_comb
    begin
        stat.action    = act_reg;
        stat.early     = early;
        stat.mod_last  = (mbit_reg == 5'd0);
        stat.walk_done = (i_reg == new_len);
        stat.dump_last = (CntW'(i_reg + 1'b1) == count_reg);
    end

    // Bank a port.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_READ)
        begin
            rda_reg <= mem_a[src_idx[IdxW-1:0]];
        end
        if (cmd.op == OP_WRITE && bank_reg)
        begin
            mem_a[i_reg[IdxW-1:0]] <= wr_data;
        end
    end

    // Bank b port.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_READ)
        begin
            rdb_reg <= mem_b[src_idx[IdxW-1:0]];
        end
        if (cmd.op == OP_WRITE && !bank_reg)
        begin
            mem_b[i_reg[IdxW-1:0]] <= wr_data;
        end
    end

    // Payload, remainder and status registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                act_reg <= in_action;
                val_reg <= ValueWidth'($signed(in_value));
                pos_reg <= CntW'(in_position);
                tgt_reg <= CntW'(in_target);
                shamt_reg <= in_shift;
                rem_reg <= '0;
                mbit_reg <= 5'(ModSteps - 1);
            end
            OP_DECODE:
            begin
                st_reg <= early ? early_st : ST_OK;
            end
            OP_MODSTEP:
            begin
                rem_reg <= rem_next;
                mbit_reg <= mbit_reg - 5'd1;
            end
            default:
            begin
            end
        endcase
    end

    // Walk index, length, live bank and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            bank_reg <= 1'b0;
            i_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_LATCH:
                begin
                    i_reg <= '0;
                end
                OP_WRITE, OP_DUMP_LOAD:
                begin
                    i_reg <= CntW'(i_reg + 1'b1);
                end
                OP_COMMIT:
                begin
                    count_reg <= new_len;
                    bank_reg <= ~bank_reg;
                end
                default:
                begin
                end
            endcase
            if (cmd.op == OP_DUMP_LOAD || cmd.op == OP_STATUS_LOAD)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_take)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_DUMP_LOAD)
        begin
            oe_reg <= 32'(rd_data);
            ol_reg <= stat.dump_last;
            os_reg <= ST_OK;
            olen_reg <= count_reg;
        end
        else if (cmd.op == OP_STATUS_LOAD)
        begin
            oe_reg <= '0;
            ol_reg <= 1'b1;
            os_reg <= st_reg;
            olen_reg <= count_reg;
        end
    end

    assign out_valid   = ov_reg;
    assign out_free    = !ov_reg || out_take;
    assign out_element = oe_reg;
    assign out_last    = ol_reg;
    assign out_status  = os_reg;
    assign out_length  = 7'(olen_reg);

    // Bookkeeping stays in range and a waiting beat holds still.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Capacity));
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        i_reg <= CntW'(Capacity));
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_DUMP_LOAD || cmd.op == OP_STATUS_LOAD) |-> out_free);
    a_beat_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_take) |=> (ov_reg && $stable(oe_reg) && $stable(ol_reg)
                                   && $stable(os_reg) && $stable(olen_reg)));

endmodule

### tb/testbench.sv
module testbench
    import pse_pkg::*;
();

    localparam int CycleLimit = 2000000;

    typedef struct packed {
        logic [30:0] shift_amount;
        logic [5:0]  target_position;
        logic [5:0]  position;
        logic [31:0] value;
        logic [2:0]  action;
    } edit_req_t;

    typedef struct {
        logic [31:0] element;
        logic        last;
        logic [1:0]  status;
        logic [6:0]  length;
    } edit_resp_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tlast;

    positional_sequence_editor_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    // Shadow copy of the sequence kept by the predictor.
    logic [31:0] seq_words [Capacity];
    int          seq_len;

    edit_req_t  pending_reqs [$];
    edit_resp_t expected_resps [$];

    int  errors = 0;
    int  cycles = 0;
    int  beats_out = 0;
    bit  quiet_phase = 0;
    bit  long_hold = 0;
    bit  hold_sender = 0;
    int  hold_count = 0;
    int  gap_in = 0;
    int  gap_out = 0;
    int  act_seen [8];

    function automatic void push_status(logic [1:0] st);
        edit_resp_t r;
        r.element = '0;
        r.last = 1'b1;
        r.status = st;
        r.length = seq_len[6:0];
        expected_resps.push_back(r);
    endfunction

    // Rebuild the sequence as new[i] = old[(i + k) mod len].
    function automatic void shift_sequence_left(int k);
        logic [31:0] tmp [Capacity];
        for (int i = 0; i < seq_len; i++) tmp[i] = seq_words[(i + k) % seq_len];
        for (int i = 0; i < seq_len; i++) seq_words[i] = tmp[i];
    endfunction

    // Apply one accepted edit request and queue the result beats it causes.
    function automatic void apply_edit(edit_req_t q);
        int p;
        int t;
        int k;
        logic [31:0] w;
        edit_resp_t r;
        p = q.position;
        t = q.target_position;
        act_seen[q.action]++;
        if (q.action == ACT_BAD) begin
            push_status(ST_RANGE);
            return;
        end
        if (q.action == ACT_INSERT) begin
            if (seq_len >= Capacity) begin
                push_status(ST_FULL);
                return;
            end
            if (p > seq_len) p = seq_len;
            for (int i = seq_len; i > p; i--) seq_words[i] = seq_words[i-1];
            seq_words[p] = q.value;
            seq_len++;
            push_status(ST_OK);
            return;
        end
        if (seq_len == 0) begin
            push_status(ST_EMPTY);
            return;
        end
        case (q.action)
            ACT_REMOVE:
            begin
                if (p >= seq_len) begin
                    push_status(ST_RANGE);
                    return;
                end
                for (int i = p; i + 1 < seq_len; i++) seq_words[i] = seq_words[i+1];
                seq_len--;
            end
            ACT_DUMP:
            begin
                for (int i = 0; i < seq_len; i++) begin
                    r.element = seq_words[i];
                    r.last = (i + 1 == seq_len);
                    r.status = ST_OK;
                    r.length = seq_len[6:0];
                    expected_resps.push_back(r);
                end
                return;
            end
            ACT_MOVE:
            begin
                if (p >= seq_len || t >= seq_len) begin
                    push_status(ST_RANGE);
                    return;
                end
                w = seq_words[p];
                if (p < t) for (int i = p; i < t; i++) seq_words[i] = seq_words[i+1];
                else for (int i = p; i > t; i--) seq_words[i] = seq_words[i-1];
                seq_words[t] = w;
            end
            ACT_REV:
            begin
                for (int i = 0; i < seq_len / 2; i++) begin
                    w = seq_words[i];
                    seq_words[i] = seq_words[seq_len-1-i];
                    seq_words[seq_len-1-i] = w;
                end
            end
            ACT_ROTL:
            begin
                k = int'(q.shift_amount % seq_len);
                if (k != 0) shift_sequence_left(k);
            end
            default:
            begin
                k = int'(q.shift_amount % seq_len);
                if (k != 0) shift_sequence_left(seq_len - k);
            end
        endcase
        push_status(ST_OK);
    endfunction

    function automatic edit_req_t make_req(logic [2:0] a, logic [31:0] v, int p, int t,
                                           logic [30:0] s);
        edit_req_t q;
        q.action = a;
        q.value = v;
        q.position = p[5:0];
        q.target_position = t[5:0];
        q.shift_amount = s;
        return q;
    endfunction

    function automatic edit_req_t random_req(int fill_bias);
        logic [2:0] a;
        int r;
        r = $urandom_range(99);
        if (r < fill_bias) a = ACT_INSERT;
        else if (r < 97) a = 3'($urandom_range(1, 6));
        else a = 3'($urandom_range(7));
        // Dumps are costly; keep them rarer.
        if (a == ACT_DUMP && $urandom_range(2) != 0) a = ACT_REV;
        return make_req(a, $urandom, $urandom_range(63), $urandom_range(63),
                        ($urandom_range(3) == 0) ? 31'($urandom) : 31'($urandom_range(130)));
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Driver: offers queued requests with random gaps.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            gap_in <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) apply_edit(edit_req_t'(s_axis_tdata[77:0]));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_in > 0) begin
                    gap_in <= gap_in - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_reqs.size() > 0 && !hold_sender) begin
                    s_axis_tdata <= {2'b00, pending_reqs.pop_front()};
                    s_axis_tvalid <= 1'b1;
                    if (!quiet_phase && $urandom_range(5) == 0) gap_in <= $urandom_range(1, 3);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness, with random bursts and one long hold.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            m_axis_tready <= 1'b0;
            gap_out <= 0;
            hold_count <= 0;
        end else if (long_hold && hold_count < 600) begin
            hold_count <= hold_count + 1;
            m_axis_tready <= 1'b0;
        end else if (gap_out > 0) begin
            gap_out <= gap_out - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!quiet_phase && $urandom_range(5) == 0) gap_out <= $urandom_range(1, 3);
        end
    end

    // Monitor: compares each result beat with the oldest expectation.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            edit_resp_t e;
            beats_out <= beats_out + 1;
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected beat data=%h last=%b", $time, m_axis_tdata,
                         m_axis_tlast);
                errors <= errors + 1;
            end else begin
                e = expected_resps.pop_front();
                if (m_axis_tdata[31:0] !== e.element || m_axis_tlast !== e.last
                    || m_axis_tdata[33:32] !== e.status || m_axis_tdata[40:34] !== e.length)
                begin
                    $display("%0t: mismatch expected elem=%h last=%b st=%0d len=%0d",
                             $time, e.element, e.last, e.status, e.length);
                    $display("%0t:          actual   elem=%h last=%b st=%0d len=%0d",
                             $time, m_axis_tdata[31:0], m_axis_tlast,
                             m_axis_tdata[33:32], m_axis_tdata[40:34]);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || s_axis_tvalid || expected_resps.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1;

        // Directed: empty cases, extremes, clamping, range errors.
        pending_reqs.push_back(make_req(ACT_REMOVE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_DUMP, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_MOVE, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_REV, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_ROTL, 0, 0, 0, 5));
        pending_reqs.push_back(make_req(ACT_ROTR, 0, 0, 0, 5));
        pending_reqs.push_back(make_req(ACT_BAD, 32'hFFFF_FFFF, 63, 63, '1));
        pending_reqs.push_back(make_req(ACT_INSERT, 32'h8000_0000, 63, 0, 0));
        pending_reqs.push_back(make_req(ACT_INSERT, 32'h7FFF_FFFF, 0, 63, '1));
        pending_reqs.push_back(make_req(ACT_INSERT, 32'hFFFF_FFFF, 1, 0, 0));
        pending_reqs.push_back(make_req(ACT_INSERT, 32'h0, 63, 0, 0));
        pending_reqs.push_back(make_req(ACT_DUMP, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_MOVE, 0, 0, 3, 0));
        pending_reqs.push_back(make_req(ACT_MOVE, 0, 3, 0, 0));
        pending_reqs.push_back(make_req(ACT_MOVE, 0, 2, 2, 0));
        pending_reqs.push_back(make_req(ACT_MOVE, 0, 63, 1, 0));
        pending_reqs.push_back(make_req(ACT_ROTL, 0, 0, 0, 31'h7FFF_FFFF));
        pending_reqs.push_back(make_req(ACT_ROTR, 0, 0, 0, 1));
        pending_reqs.push_back(make_req(ACT_ROTL, 0, 0, 0, 8));
        pending_reqs.push_back(make_req(ACT_REV, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(ACT_REMOVE, 0, 63, 0, 0));
        pending_reqs.push_back(make_req(ACT_REMOVE, 0, 1, 0, 0));
        pending_reqs.push_back(make_req(ACT_DUMP, 0, 0, 0, 0));
        wait_drained();

        // Fill to capacity and overflow, while the receiver holds off.
        long_hold = 1;
        for (int i = 0; i < 66; i++)
            pending_reqs.push_back(make_req(ACT_INSERT, $urandom, $urandom_range(63), 0, 0));
        pending_reqs.push_back(make_req(ACT_DUMP, 0, 0, 0, 0));
        wait_drained();
        long_hold = 0;

        // Sender pause: requests queue up while the sender is held off, then drain.
        hold_sender = 1;
        for (int i = 0; i < 4; i++) pending_reqs.push_back(random_req(30));
        repeat (20) @(posedge clk);
        hold_sender = 0;
        wait_drained();

        // Random mix: bias toward inserts early to build depth.
        for (int i = 0; i < 200; i++) pending_reqs.push_back(random_req(i < 100 ? 55 : 35));
        wait_drained();
        quiet_phase = 1;
        for (int i = 0; i < 40; i++) pending_reqs.push_back(random_req(40));
        pending_reqs.push_back(make_req(ACT_DUMP, 0, 0, 0, 0));
        wait_drained();
        repeat (300) @(posedge clk);

        $display("covered %0d inserts, %0d removes, %0d dumps, %0d moves, %0d reverses,",
                 act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4]);
        $display("%0d/%0d rotations, %0d bad codes; %0d result beats checked",
                 act_seen[5], act_seen[6], act_seen[7], beats_out);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
